// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, operation codes and the result record of the sorted
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // Priority levels: one ring per level
  localparam int PRIO_BITS = 2;
  localparam int NUM_PRIO  = 2 ** PRIO_BITS;

  // Fixed port widths
  localparam int TAG_PORT_BITS   = 16;
  localparam int COUNT_PORT_BITS = 5;

  // Operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // One result record
  typedef struct packed {
    logic                       popped_valid;
    logic [PRIO_BITS-1:0]       popped_priority;
    logic [TAG_PORT_BITS-1:0]   popped_tag;
    logic [PRIO_BITS-1:0]       front_priority;
    logic [TAG_PORT_BITS-1:0]   front_tag;
    logic [COUNT_PORT_BITS-1:0] entry_count;
    logic                       is_empty;
    logic                       overflow;
  } result_t;

endpackage

// File: rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded stable priority queue. Entries live in one RAM split into one ring
// per priority level; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_ready  | func, entry_priority, entry_tag
//  out     | output    | out_valid/out_ready| popped_*, front_*, entry_count,
//          |           |                    | is_empty, overflow
//
//  Push, pop of an empty queue and a pop that empties it finish when accepted.
//  Other pops pass through S_READ, the RAM read of the next front entry, and block input meanwhile.
//  Reset clears the ring pointers and counts; no clearing pass over the RAM.
//  The output register holds one result while the next item is accepted; a
//  second finished result waits in a hold register and stops input transfers.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [PRIO_BITS-1:0]       entry_priority,
  input  logic [TAG_PORT_BITS-1:0]   entry_tag,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       popped_valid,
  output logic [PRIO_BITS-1:0]       popped_priority,
  output logic [TAG_PORT_BITS-1:0]   popped_tag,
  output logic [PRIO_BITS-1:0]       front_priority,
  output logic [TAG_PORT_BITS-1:0]   front_tag,
  output logic [COUNT_PORT_BITS-1:0] entry_count,
  output logic                       is_empty,
  output logic                       overflow
);

  localparam int PW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int AW        = PRIO_BITS + PW;
  localparam int RAM_DEPTH = NUM_PRIO * (2 ** PW);
  localparam int SUM_W     = CW + PRIO_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  // Width helpers
  function automatic logic [TAG_PORT_BITS-1:0] tag_to_port(input logic [TAG_BITS-1:0] t);
    logic [TAG_BITS+TAG_PORT_BITS-1:0] pad;
    pad = {{TAG_PORT_BITS{1'b0}}, t};
    return pad[TAG_PORT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_PORT_BITS-1:0] cnt_to_port(input logic [CW-1:0] c);
    logic [CW+COUNT_PORT_BITS-1:0] pad;
    pad = {{COUNT_PORT_BITS{1'b0}}, c};
    return pad[COUNT_PORT_BITS-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Queue state
  logic [1:0]           state;
  logic [PW-1:0]        head   [NUM_PRIO];
  logic [PW-1:0]        tail   [NUM_PRIO];
  logic [CW-1:0]        pcount [NUM_PRIO];
  logic [CW-1:0]        total;
  logic [PRIO_BITS-1:0] front_prio;
  logic [TAG_BITS-1:0]  front_tg;
  logic [PRIO_BITS-1:0] rd_prio;

  // Result staging
  result_t out_res;
  result_t hold_res;
  result_t res_now;
  result_t res_read;

  // Handshake and decode
  logic                         in_fire;
  logic                         out_free;
  logic                         out_load;
  logic                         is_push;
  logic                         full;
  logic                         empty_q;
  logic                         push_front_new;
  logic                         needs_read;
  logic [TAG_BITS+TAG_PORT_BITS-1:0] in_tag_pad;
  logic [TAG_BITS-1:0]          in_tag;
  logic [CW-1:0]                cnt_after [NUM_PRIO];
  logic [PRIO_BITS-1:0]         q;
  logic [PW-1:0]                rd_ptr;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [TAG_BITS-1:0]          ram_rdata;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign is_push    = (func == FUNC_PUSH);
  assign full       = (total == CW'(DEPTH));
  assign empty_q    = (total == '0);
  assign in_tag_pad = {{TAG_BITS{1'b0}}, entry_tag};
  assign in_tag     = in_tag_pad[TAG_BITS-1:0];
  assign push_front_new = empty_q || (entry_priority > front_prio);
  assign needs_read = !is_push && (total > CW'(1));

  // A finished result enters the output register this cycle
  assign out_load = out_free &&
                    ((in_fire && !needs_read) || (state == S_READ) || (state == S_HOLD));

  // Next front after a pop: highest level still holding entries
  always_comb begin
    for (int p = 0; p < NUM_PRIO; p++) begin
      cnt_after[p] = pcount[p] - CW'(PRIO_BITS'(p) == front_prio);
    end
    q = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      if (cnt_after[p] != '0) begin
        q = PRIO_BITS'(p);
      end
    end
    rd_ptr = (q == front_prio) ? ptr_inc(head[front_prio]) : head[q];
  end

  // Result of the accepted item (front left open when a read follows)
  always_comb begin
    res_now = '0;
    if (is_push) begin
      res_now.overflow = full;
      if (full) begin
        res_now.front_priority = front_prio;
        res_now.front_tag      = tag_to_port(front_tg);
        res_now.entry_count    = cnt_to_port(total);
        res_now.is_empty       = empty_q;
      end else begin
        res_now.front_priority = push_front_new ? entry_priority : front_prio;
        res_now.front_tag      = push_front_new ? tag_to_port(in_tag) : tag_to_port(front_tg);
        res_now.entry_count    = cnt_to_port(total + 1'b1);
        res_now.is_empty       = 1'b0;
      end
    end else begin
      res_now.popped_valid    = !empty_q;
      res_now.popped_priority = front_prio;
      res_now.popped_tag      = tag_to_port(front_tg);
      res_now.entry_count     = empty_q ? '0 : cnt_to_port(total - 1'b1);
      res_now.is_empty        = !needs_read;
    end
  end

  // Pop result completed with the front read from RAM
  always_comb begin
    res_read                = hold_res;
    res_read.front_priority = rd_prio;
    res_read.front_tag      = tag_to_port(ram_rdata);
  end

  // RAM access
  assign ram_we    = in_fire && is_push && !full;
  assign ram_waddr = {entry_priority, tail[entry_priority]};
  assign ram_re    = in_fire && needs_read;
  assign ram_raddr = {q, rd_ptr};

  spq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tag),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      total      <= '0;
      front_prio <= '0;
      front_tg   <= '0;
      for (int p = 0; p < NUM_PRIO; p++) begin
        head[p]   <= '0;
        tail[p]   <= '0;
        pcount[p] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            // push into the tail of its level
            if (is_push && !full) begin
              tail[entry_priority]   <= ptr_inc(tail[entry_priority]);
              pcount[entry_priority] <= pcount[entry_priority] + 1'b1;
              total                  <= total + 1'b1;
              if (push_front_new) begin
                front_prio <= entry_priority;
                front_tg   <= in_tag;
              end
            end
            // pop from the head of the front level
            if (!is_push && !empty_q) begin
              head[front_prio]   <= ptr_inc(head[front_prio]);
              pcount[front_prio] <= pcount[front_prio] - 1'b1;
              total              <= total - 1'b1;
              if (!needs_read) begin
                front_prio <= '0;
                front_tg   <= '0;
              end
              rd_prio <= q;
            end
            if (needs_read) begin
              hold_res <= res_now;
              state    <= S_READ;
            end else if (out_free) begin
              out_res   <= res_now;
              out_valid <= 1'b1;
            end else begin
              hold_res <= res_now;
              state    <= S_HOLD;
            end
          end
        end
        S_READ: begin
          front_prio <= rd_prio;
          front_tg   <= ram_rdata;
          if (out_free) begin
            out_res   <= res_read;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            hold_res <= res_read;
            state    <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_res   <= hold_res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  assign popped_valid    = out_res.popped_valid;
  assign popped_priority = out_res.popped_priority;
  assign popped_tag      = out_res.popped_tag;
  assign front_priority  = out_res.front_priority;
  assign front_tag       = out_res.front_tag;
  assign entry_count     = out_res.entry_count;
  assign is_empty        = out_res.is_empty;
  assign overflow        = out_res.overflow;

  // Sum of the per-level counts, for checking
  logic [SUM_W-1:0] pcount_sum;
  always_comb begin
    pcount_sum = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      pcount_sum = pcount_sum + SUM_W'(pcount[p]);
    end
  end

  // Assertions
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    pcount_sum == SUM_W'(total))
    else $error("level counts do not add up to total");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (total == '0) |-> (front_prio == '0 && front_tg == '0))
    else $error("front entry not cleared on empty queue");

  a_read_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state != S_READ))
    else $error("front read lasted more than one cycle");

  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (state == S_READ))
    else $error("RAM read issued without read state");

endmodule
